@@ hw/rtl/tbpc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbpc_pkg
// Shared types and constants for the timed blind position controller.
// ----------------------------------------------------------------------------
package tbpc_pkg;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 1;
    localparam int POS_W     = 7;
    localparam int OFF_W     = 8;
    localparam int TGT_W     = 8;

    localparam logic [POS_W-1:0] FULL_SCALE = 7'd100;
    localparam logic [CFG_W-1:0] CFG_RESET  = 24'd30000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TO_ZERO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TO_FULL = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_MOVE = 2'd1,
        OP_STOP = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        MODE_AT_ZERO = 3'd0,
        MODE_AT_FULL = 3'd1,
        MODE_BETWEEN = 3'd2,
        MODE_UP      = 3'd3,
        MODE_DOWN    = 3'd4
    } t_mode;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage
`default_nettype wire

@@ hw/rtl/tbpc_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbpc_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbpc_div #(
    parameter int NUM_W = 39,
    parameter int DEN_W = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [NUM_W-1:0]       i_num,
    input  wire logic [DEN_W-1:0]       i_den,
    output logic [NUM_W-1:0]            o_quot,
    output tbpc_pkg::t_div_stat         o_stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot, n_quot;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    logic [DEN_W:0]   shifted;
    logic             ge;

    always_comb begin
        shifted = {r_rem, r_quot[NUM_W-1]};
        ge      = shifted >= {1'b0, r_den};

        n_quot = r_quot;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = r_done;

        if (i_start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_den  = i_den;
            n_cnt  = CNT_W'(NUM_W);
            n_busy = 1'b1;
            n_done = 1'b0;
        end else if (r_busy) begin
            n_quot = {r_quot[NUM_W-2:0], ge};
            n_rem  = ge ? DEN_W'(shifted - {1'b0, r_den}) : shifted[DEN_W-1:0];
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_quot      = r_quot;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
`default_nettype wire

@@ hw/rtl/timed_blind_position_controller_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// timed_blind_position_controller_top
// Open-loop timed blind positioner: sequencer around one serial divider.
// ----------------------------------------------------------------------------
// Divider: numerator width W = max(TIME_BITS+7, 31) bits; every scaling step
//   shares the one divider, which yields one quotient bit per cycle.
// Throughput: one word at a time; stall stays high until the result is taken.
// Reset: synchronous active low; position 0, stopped at zero, both travel
//   times 30000 ms.
module timed_blind_position_controller_top #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // item in
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [1:0]                      i_operation,
    input  wire logic [tbpc_pkg::TGT_W-1:0]      i_target_percent,
    // result out
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [tbpc_pkg::POS_W-1:0]           o_position_now,
    output logic [2:0]                           o_motion_mode,
    output logic                                 o_motor_power,
    output logic                                 o_direction_level,
    output logic                                 o_update_raised,
    output logic                                 o_at_rest,
    // config
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tbpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tbpc_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int NUM_W  = (TIME_BITS + 7 > 31) ? TIME_BITS + 7 : 31;
    localparam int PROD_W = tbpc_pkg::POS_W + tbpc_pkg::CFG_W;
    localparam int POS_W  = tbpc_pkg::POS_W;
    localparam int OFF_W  = tbpc_pkg::OFF_W;
    localparam int CFG_W  = tbpc_pkg::CFG_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EVAL  = 8'b0000_0010,
        S_SCALE = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_POST  = 8'b0001_0000,
        S_STOP  = 8'b0010_0000,
        S_START = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state                       r_state, n_state;
    tbpc_pkg::t_op                r_op, n_op;
    logic [tbpc_pkg::TGT_W-1:0]   r_target, n_target;
    logic [CFG_W-1:0]             r_tz, n_tz;
    logic [CFG_W-1:0]             r_tf, n_tf;
    logic [POS_W-1:0]             r_stored, n_stored;
    logic signed [OFF_W-1:0]      r_offset, n_offset;
    tbpc_pkg::t_mode              r_mode, n_mode;
    logic [TIME_BITS-1:0]         r_elapsed, n_elapsed;
    logic [TIME_BITS-1:0]         r_expected, n_expected;
    logic                         r_update, n_update;
    logic                         r_timeout, n_timeout;
    logic                         r_div_expect, n_div_expect;

    // divider
    logic                         div_start;
    logic [NUM_W-1:0]             div_num;
    logic [CFG_W-1:0]             div_den;
    logic [NUM_W-1:0]             div_quot;
    tbpc_pkg::t_div_stat          div_stat;

    // datapath
    logic [CFG_W-1:0]             eff_tz, eff_tf, den_dir, t_move;
    logic                         moving;
    logic [TIME_BITS-1:0]         elapsed_inc;
    logic [NUM_W-1:0]             elapsed_w, scaled;
    logic [POS_W-1:0]             dist_lim;
    logic [POS_W:0]               up_sum;
    logic [POS_W-1:0]             fold_pos;
    logic signed [OFF_W-1:0]      new_off;
    logic [POS_W-1:0]             np, move_dist;
    logic [PROD_W-1:0]            prod;
    logic [TIME_BITS-1:0]         exp_lim;
    logic signed [OFF_W:0]        pos_sum;
    tbpc_pkg::t_mode              rest_mode;

    tbpc_div #(
        .NUM_W (NUM_W),
        .DEN_W (CFG_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (div_quot),
        .o_stat  (div_stat)
    );

    always_comb begin
        eff_tz  = (r_tz == '0) ? CFG_W'(1) : r_tz;
        eff_tf  = (r_tf == '0) ? CFG_W'(1) : r_tf;
        moving  = (r_mode == tbpc_pkg::MODE_UP) || (r_mode == tbpc_pkg::MODE_DOWN);
        den_dir = (r_mode == tbpc_pkg::MODE_UP) ? eff_tf : eff_tz;

        elapsed_inc = (r_elapsed == TIME_MAX) ? r_elapsed : r_elapsed + 1'b1;
        // elapsed * 100 as shifts
        elapsed_w = NUM_W'(r_elapsed);
        scaled    = (elapsed_w << 6) + (elapsed_w << 5) + (elapsed_w << 2);

        dist_lim = (div_quot > NUM_W'(tbpc_pkg::FULL_SCALE)) ?
                   tbpc_pkg::FULL_SCALE : div_quot[POS_W-1:0];
        up_sum   = {1'b0, r_stored} + {1'b0, dist_lim};
        if (r_mode == tbpc_pkg::MODE_UP) begin
            fold_pos = (up_sum > {1'b0, tbpc_pkg::FULL_SCALE}) ?
                       tbpc_pkg::FULL_SCALE : up_sum[POS_W-1:0];
            new_off  = $signed({1'b0, dist_lim});
        end else begin
            fold_pos = (dist_lim >= r_stored) ? '0 : r_stored - dist_lim;
            new_off  = -$signed({1'b0, dist_lim});
        end

        np = (r_target > tbpc_pkg::TGT_W'(tbpc_pkg::FULL_SCALE)) ?
             tbpc_pkg::FULL_SCALE : r_target[POS_W-1:0];
        if (r_stored < np) begin
            move_dist = np - r_stored;
            t_move    = eff_tf;
        end else begin
            move_dist = r_stored - np;
            t_move    = eff_tz;
        end
        prod = PROD_W'(move_dist) * PROD_W'(t_move);

        exp_lim = (div_quot > NUM_W'(TIME_MAX)) ? TIME_MAX : div_quot[TIME_BITS-1:0];

        if (r_stored == '0) begin
            rest_mode = tbpc_pkg::MODE_AT_ZERO;
        end else if (r_stored >= tbpc_pkg::FULL_SCALE) begin
            rest_mode = tbpc_pkg::MODE_AT_FULL;
        end else begin
            rest_mode = tbpc_pkg::MODE_BETWEEN;
        end

        pos_sum = $signed({2'b00, r_stored}) + $signed({r_offset[OFF_W-1], r_offset});
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_target     = r_target;
        n_tz         = r_tz;
        n_tf         = r_tf;
        n_stored     = r_stored;
        n_offset     = r_offset;
        n_mode       = r_mode;
        n_elapsed    = r_elapsed;
        n_expected   = r_expected;
        n_update     = r_update;
        n_timeout    = r_timeout;
        n_div_expect = r_div_expect;
        div_start    = 1'b0;
        div_num      = scaled;
        div_den      = den_dir;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tbpc_pkg::CFG_TO_ZERO: n_tz = i_cfg_data;
                tbpc_pkg::CFG_TO_FULL: n_tf = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op     = tbpc_pkg::t_op'(i_operation);
                    n_target = i_target_percent;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                n_update     = 1'b0;
                n_timeout    = 1'b0;
                n_div_expect = 1'b0;
                unique case (r_op) inside
                    tbpc_pkg::OP_TICK: begin
                        if (moving) begin
                            n_elapsed = elapsed_inc;
                            if (elapsed_inc >= r_expected) begin
                                n_timeout = 1'b1;
                                n_update  = 1'b1;
                                n_state   = (r_expected != '0) ? S_SCALE : S_STOP;
                            end else begin
                                n_state = S_SCALE;
                            end
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                    tbpc_pkg::OP_MOVE, tbpc_pkg::OP_STOP: begin
                        n_update = 1'b1;
                        n_state  = (moving && r_expected != '0) ? S_SCALE : S_STOP;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_SCALE: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_stat.done && !div_stat.busy) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (r_div_expect) begin
                    n_expected = exp_lim;
                    n_state    = S_OUT;
                end else if (r_op == tbpc_pkg::OP_TICK && !r_timeout) begin
                    if (new_off != r_offset) begin
                        n_update = 1'b1;
                        // reaching an end stops the move, folding the same distance
                        if (fold_pos == '0 || fold_pos == tbpc_pkg::FULL_SCALE) begin
                            n_stored = fold_pos;
                            n_state  = S_STOP;
                        end else begin
                            n_offset = new_off;
                            n_state  = S_OUT;
                        end
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_stored = fold_pos;
                    n_state  = S_STOP;
                end
            end
            S_STOP: begin
                n_elapsed  = '0;
                n_expected = '0;
                n_offset   = '0;
                n_mode     = rest_mode;
                n_state    = (r_op == tbpc_pkg::OP_MOVE) ? S_START : S_OUT;
            end
            S_START: begin
                if (r_stored != np) begin
                    n_mode       = (r_stored < np) ? tbpc_pkg::MODE_UP : tbpc_pkg::MODE_DOWN;
                    div_start    = 1'b1;
                    div_num      = NUM_W'(prod);
                    div_den      = CFG_W'(tbpc_pkg::FULL_SCALE);
                    n_div_expect = 1'b1;
                    n_state      = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tz         <= tbpc_pkg::CFG_RESET;
            r_tf         <= tbpc_pkg::CFG_RESET;
            r_stored     <= '0;
            r_offset     <= '0;
            r_mode       <= tbpc_pkg::MODE_AT_ZERO;
            r_elapsed    <= '0;
            r_expected   <= '0;
            r_update     <= 1'b0;
            r_timeout    <= 1'b0;
            r_div_expect <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tz         <= n_tz;
            r_tf         <= n_tf;
            r_stored     <= n_stored;
            r_offset     <= n_offset;
            r_mode       <= n_mode;
            r_elapsed    <= n_elapsed;
            r_expected   <= n_expected;
            r_update     <= n_update;
            r_timeout    <= n_timeout;
            r_div_expect <= n_div_expect;
        end
        r_op     <= n_op;
        r_target <= n_target;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_cfg_ready = 1'b1;

    assign o_position_now    = pos_sum[OFF_W] ? '0 :
                               (pos_sum > $signed({2'b00, tbpc_pkg::FULL_SCALE})) ?
                               tbpc_pkg::FULL_SCALE : pos_sum[POS_W-1:0];
    assign o_motion_mode     = r_mode;
    assign o_motor_power     = moving;
    assign o_direction_level = (r_mode != tbpc_pkg::MODE_DOWN);
    assign o_update_raised   = r_update;
    assign o_at_rest         = (r_offset == '0);

endmodule
`default_nettype wire

@@ bench/blind_status_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// blind_status_checker
// Follows the item, status and register channels of the blind controller,
// predicts the status word for each accepted item and compares the words the
// block returns, oldest first. Reports a running failure count and the number
// of words still outstanding.
// ----------------------------------------------------------------------------
module blind_status_checker
    import tbpc_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire logic [1:0]            i_operation,
    input  wire logic [TGT_W-1:0]      i_target_percent,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [POS_W-1:0]      i_position_now,
    input  wire logic [2:0]            i_motion_mode,
    input  wire logic                  i_motor_power,
    input  wire logic                  i_direction_level,
    input  wire logic                  i_update_raised,
    input  wire logic                  i_at_rest,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    output int                         o_errors,
    output int                         o_pending
);

    localparam longint unsigned TIME_MAX = (64'd1 << TIME_BITS) - 64'd1;
    localparam int SCALE = int'(FULL_SCALE);

    typedef struct packed {
        logic [POS_W-1:0] position;
        t_mode            mode;
        logic             motor;
        logic             direction;
        logic             update;
        logic             rest;
    } blind_word_t;

    logic [CFG_W-1:0] open_ms;
    logic [CFG_W-1:0] close_ms;
    int               stored_pct;
    int               offset_pct;
    t_mode            blind_mode;
    longint unsigned  elapsed_ms;
    longint unsigned  planned_ms;
    blind_word_t      expected_status[$];
    int               err_cnt = 0;
    int               pending = 0;

    assign o_errors  = err_cnt;
    assign o_pending = pending;

    // a travel time of zero behaves as 1 ms
    function automatic longint unsigned span(input logic [CFG_W-1:0] t);
        return (t == '0) ? 64'd1 : 64'(t);
    endfunction

    function automatic int clamp_pct(input int v);
        return (v < 0) ? 0 : ((v > SCALE) ? SCALE : v);
    endfunction

    // percent covered so far in the current move, capped at full scale
    function automatic int run_pct(input logic [CFG_W-1:0] t);
        longint unsigned d;
        d = elapsed_ms * 64'(SCALE) / span(t);
        return (d > 64'(SCALE)) ? SCALE : int'(d);
    endfunction

    function automatic logic moving();
        return blind_mode == MODE_UP || blind_mode == MODE_DOWN;
    endfunction

    task automatic halt_blind();
        // a zero-length move folds nothing in
        if (moving() && planned_ms != 0) begin
            if (blind_mode == MODE_UP)
                stored_pct = clamp_pct(stored_pct + run_pct(close_ms));
            else
                stored_pct = clamp_pct(stored_pct - run_pct(open_ms));
        end
        elapsed_ms = 0;
        planned_ms = 0;
        offset_pct = 0;
        if (stored_pct == 0)
            blind_mode = MODE_AT_ZERO;
        else if (stored_pct >= SCALE)
            blind_mode = MODE_AT_FULL;
        else
            blind_mode = MODE_BETWEEN;
    endtask

    task automatic advance_blind(input logic [1:0] op, input logic [TGT_W-1:0] tgt,
                                 output blind_word_t w);
        int              goal;
        int              prev;
        int              now_pct;
        longint unsigned span_ms;
        logic            upd;
        upd = 1'b0;
        case (op)
            OP_TICK: begin
                if (moving()) begin
                    if (elapsed_ms < TIME_MAX)
                        elapsed_ms++;
                    if (elapsed_ms >= planned_ms) begin
                        halt_blind();
                        upd = 1'b1;
                    end else begin
                        prev = offset_pct;
                        offset_pct = (blind_mode == MODE_UP) ? run_pct(close_ms)
                                                             : -run_pct(open_ms);
                        if (prev != offset_pct) begin
                            upd = 1'b1;
                            now_pct = clamp_pct(stored_pct + offset_pct);
                            if (now_pct == 0 || now_pct == SCALE)
                                halt_blind();
                        end
                    end
                end
            end
            OP_MOVE: begin
                goal = (tgt > SCALE) ? SCALE : int'(tgt);
                halt_blind();
                span_ms = 0;
                if (stored_pct < goal) begin
                    blind_mode = MODE_UP;
                    span_ms = 64'(goal - stored_pct) * span(close_ms) / 64'(SCALE);
                end else if (stored_pct > goal) begin
                    blind_mode = MODE_DOWN;
                    span_ms = 64'(stored_pct - goal) * span(open_ms) / 64'(SCALE);
                end
                if (moving()) begin
                    planned_ms = (span_ms > TIME_MAX) ? TIME_MAX : span_ms;
                    elapsed_ms = 0;
                end
                upd = 1'b1;
            end
            OP_STOP: begin
                halt_blind();
                upd = 1'b1;
            end
            default: ;
        endcase
        w.position  = POS_W'(clamp_pct(stored_pct + offset_pct));
        w.mode      = blind_mode;
        w.motor     = moving();
        w.direction = (blind_mode != MODE_DOWN);
        w.update    = upd;
        w.rest      = (offset_pct == 0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            err_cnt++;
            $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        blind_word_t want;
        if (!i_rst_n) begin
            open_ms    = CFG_RESET;
            close_ms   = CFG_RESET;
            stored_pct = 0;
            offset_pct = 0;
            blind_mode = MODE_AT_ZERO;
            elapsed_ms = 0;
            planned_ms = 0;
            expected_status.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_TO_ZERO)
                    open_ms = i_cfg_data;
                else
                    close_ms = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                advance_blind(i_operation, i_target_percent, want);
                expected_status.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_status.size() == 0) begin
                    err_cnt++;
                    $display("%0t status word with none expected: position %0d mode %0d",
                             $time, i_position_now, i_motion_mode);
                end else begin
                    want = expected_status.pop_front();
                    check_field("position_now", int'(want.position), int'(i_position_now));
                    check_field("motion_mode", int'(want.mode), int'(i_motion_mode));
                    check_field("motor_power", int'(want.motor), int'(i_motor_power));
                    check_field("direction_level", int'(want.direction),
                                int'(i_direction_level));
                    check_field("update_raised", int'(want.update), int'(i_update_raised));
                    check_field("at_rest", int'(want.rest), int'(i_at_rest));
                end
            end
        end
        pending <= expected_status.size();
    end

endmodule
`default_nettype wire

@@ bench/timed_blind_position_controller_top_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// timed_blind_position_controller_top_tb
// Drives tick, move and stop words into the blind controller across several
// travel-time settings, with random gaps and stalls on both channels and one
// long output hold-off. The checker predicts and compares every status word.
// ----------------------------------------------------------------------------
module timed_blind_position_controller_top_tb;
    import tbpc_pkg::*;

    localparam int TIME_BITS = 32;
    localparam logic [1:0] OP_SPARE = 2'd3;     // unused code, must change nothing
    localparam logic [CFG_W-1:0] TRAVEL_MAX = '1;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT = 200;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic [1:0]           i_operation = OP_TICK;
    logic [TGT_W-1:0]     i_target_percent = '0;
    logic                 i_stall = 1'b1;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_TO_ZERO;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic [POS_W-1:0]     o_position_now;
    logic [2:0]           o_motion_mode;
    logic                 o_motor_power;
    logic                 o_direction_level;
    logic                 o_update_raised;
    logic                 o_at_rest;
    logic                 o_cfg_ready;
    int                   errors;
    int                   pending;
    int                   feed_count = 0;
    int                   take_count = 0;

    timed_blind_position_controller_top #(.TIME_BITS(TIME_BITS)) i_dut (.*);

    blind_status_checker #(.TIME_BITS(TIME_BITS)) i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_operation      (i_operation),
        .i_target_percent (i_target_percent),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_position_now   (o_position_now),
        .i_motion_mode    (o_motion_mode),
        .i_motor_power    (o_motor_power),
        .i_direction_level(o_direction_level),
        .i_update_raised  (o_update_raised),
        .i_at_rest        (o_at_rest),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_errors         (errors),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_word(input logic [1:0] op, input logic [TGT_W-1:0] tgt);
        int gap;
        // every fourth stretch of 40 words goes back to back
        gap = ((feed_count / 40) % 4 == 1) ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_operation      <= op;
        i_target_percent <= tgt;
        do @(posedge i_clk); while (o_stall);
        feed_count++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_travel(input logic [CFG_W-1:0] to_zero, input logic [CFG_W-1:0] to_full);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_TO_ZERO;
        i_cfg_data  <= to_zero;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_TO_FULL;
        i_cfg_data  <= to_full;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [TGT_W-1:0] aim_percent();
        case ($urandom_range(0, 5))
            0: return TGT_W'($urandom);
            1: return $urandom_range(0, 1) ? TGT_W'(100) : TGT_W'(0);
            default: return TGT_W'($urandom_range(0, 100));
        endcase
    endfunction

    // mostly a move followed by a run of ticks; stray ticks and spare codes
    // are noise and do not count toward the quota
    task automatic random_traffic(input int quota);
        int sent;
        int pick;
        int run_len;
        sent = 0;
        while (sent < quota) begin
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
                send_word(OP_MOVE, aim_percent());
                run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 150)
                                                      : $urandom_range(0, 25);
                // keep the run inside the quota
                if (run_len > quota - sent - 1)
                    run_len = quota - sent - 1;
                repeat (run_len) send_word(OP_TICK, TGT_W'($urandom));
                sent += run_len + 1;
            end else if (pick < 16) begin
                send_word(OP_STOP, TGT_W'($urandom));
                sent++;
            end else if (pick < 18) begin
                send_word(OP_SPARE, TGT_W'($urandom));
            end else begin
                send_word(OP_TICK, TGT_W'($urandom));
            end
        end
    endtask

    initial begin : sink
        int waits;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (take_count == HOLD_AT)
                waits = HOLD_CYCLES;    // let the block back up into its input
            else if ((take_count / 40) % 4 == 2)
                waits = 0;
            else
                waits = $urandom_range(0, 7);
            if (waits > 0) begin
                i_stall <= 1'b1;
                repeat (waits) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            take_count++;
        end
    end

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset travel times: moves are far too slow to finish
        send_word(OP_TICK, 8'd0);
        send_word(OP_SPARE, 8'd255);
        send_word(OP_STOP, 8'd0);
        send_word(OP_MOVE, 8'd0);
        send_word(OP_MOVE, 8'd255);
        repeat (3) send_word(OP_TICK, 8'd255);
        send_word(OP_STOP, 8'd170);

        // zero open time (acts as 1 ms), 2 ms close time
        drain();
        set_travel('0, 24'd2);
        send_word(OP_MOVE, 8'd100);
        send_word(OP_TICK, 8'd0);
        send_word(OP_TICK, 8'd0);
        send_word(OP_TICK, 8'd85);
        send_word(OP_MOVE, 8'd40);      // computes to 0 ms
        send_word(OP_TICK, 8'd0);
        send_word(OP_MOVE, 8'd255);     // already closed
        send_word(OP_MOVE, 8'd0);
        send_word(OP_TICK, 8'd0);
        send_word(OP_MOVE, 8'd70);
        send_word(OP_STOP, 8'd0);
        send_word(OP_MOVE, 8'd100);
        send_word(OP_TICK, 8'd0);
        send_word(OP_STOP, 8'd0);       // halfway
        send_word(OP_MOVE, 8'd0);
        send_word(OP_TICK, 8'd0);
        send_word(OP_SPARE, 8'd0);

        drain();
        set_travel(TRAVEL_MAX, 24'd1);
        random_traffic(50);
        drain();
        set_travel(24'd1, TRAVEL_MAX);
        random_traffic(50);
        drain();
        set_travel(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(0, 8)));
        random_traffic(100);
        drain();
        set_travel(CFG_W'($urandom_range(20, 100)), CFG_W'($urandom_range(20, 100)));
        random_traffic(110);
        repeat (2) begin
            drain();
            set_travel(CFG_W'($urandom_range(1, 400)), CFG_W'($urandom_range(1, 400)));
            random_traffic(110);
        end

        drain();
        repeat (120) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
